/* rtl/core/pbrqs_pkg.sv */
// types and codes shared by the ready-queue scheduler modules
package pbrqs_pkg;

  localparam int TID_W = 4;
  localparam int PRIO_W = 5;
  localparam int MASK_W = 32;

  typedef enum logic [1:0] {
    ACT_INSERT   = 2'd0,
    ACT_REMOVE   = 2'd1,
    ACT_SCHEDULE = 2'd2,
    ACT_SPARE    = 2'd3
  } action_t;

  typedef struct packed {
    action_t             action;
    logic [TID_W-1:0]    thread_id;
    logic [PRIO_W-1:0]   priority_req;
  } item_t;

  typedef struct packed {
    logic                error;
    logic                switched;
    logic                has_ready;
    logic                from_valid;
    logic [TID_W-1:0]    left_thread;
    logic [TID_W-1:0]    picked_thread;
    logic [PRIO_W-1:0]   to_priority;
    logic [MASK_W-1:0]   ready_mask;
  } result_t;

  typedef struct packed {
    logic accept;
    logic rd_link;
    logic rd_level;
    logic commit;
  } ctrl_cmd_t;

  typedef struct packed {
    logic out_free;
  } dp_status_t;

endpackage

/* rtl/core/pbrqs_ctrl.sv */
// sequencing controller for the ready-queue scheduler
module pbrqs_ctrl (
  input  logic                 clk,
  input  logic                 rst,
  input  logic                 item_valid,
  output logic                 item_stall,
  input  pbrqs_pkg::dp_status_t status,
  output pbrqs_pkg::ctrl_cmd_t  cmd
);
  import pbrqs_pkg::*;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_LINK,
    ST_LEVEL,
    ST_COMMIT
  } state_t;

  state_t state;

  assign item_stall   = rst || (state != ST_IDLE);
  assign cmd.accept   = item_valid && !item_stall;
  assign cmd.rd_link  = (state == ST_LINK);
  assign cmd.rd_level = (state == ST_LEVEL);
  assign cmd.commit   = (state == ST_COMMIT) && status.out_free;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      case (state)
        ST_IDLE: begin
          if (cmd.accept) state <= ST_LINK;
        end
        ST_LINK:  state <= ST_LEVEL;
        ST_LEVEL: state <= ST_COMMIT;
        ST_COMMIT: begin
          if (status.out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

/* rtl/core/pbrqs_datapath.sv */
// queue memories, ready bitmap, running thread and result register
module pbrqs_datapath #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int THREAD_COUNT    = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  pbrqs_pkg::item_t      item,
  input  pbrqs_pkg::ctrl_cmd_t  cmd,
  output pbrqs_pkg::dp_status_t status,
  output logic                  result_valid,
  input  logic                  result_stall,
  output pbrqs_pkg::result_t    result
);
  import pbrqs_pkg::*;

  localparam int LW  = $clog2(PRIORITY_LEVELS);
  localparam int TIW = $clog2(THREAD_COUNT);

  // latched item
  action_t           act_q;
  logic [TID_W-1:0]  tid_q;
  logic [LW-1:0]     lvl_q;

  // control state
  logic [PRIORITY_LEVELS-1:0] ready;
  logic [THREAD_COUNT-1:0]    queued;
  logic                       running_valid;
  logic [TID_W-1:0]           running_thread;

  // memories
  logic [TID_W-1:0] head_mem  [PRIORITY_LEVELS];
  logic [TID_W-1:0] tail_mem  [PRIORITY_LEVELS];
  logic [TID_W-1:0] next_mem  [THREAD_COUNT];
  logic [TID_W-1:0] prev_mem  [THREAD_COUNT];
  logic [LW-1:0]    level_mem [THREAD_COUNT];

  // registered read data
  logic [LW-1:0]    level_rd;
  logic [TID_W-1:0] next_rd;
  logic [TID_W-1:0] prev_rd;
  logic [TID_W-1:0] head_rd;
  logic [TID_W-1:0] tail_rd;
  logic [LW-1:0]    lvl_rq;

  logic [LW-1:0]    lvl_sat;
  logic [LW-1:0]    best_c;
  logic [LW-1:0]    lvl_addr;
  logic [TIW-1:0]   tix;
  logic             in_range;
  logic             is_ins;
  logic             is_rem;
  logic             ins_ok;
  logic             rem_ok;
  logic             lvl_busy;
  logic             is_head;
  logic             is_tail;
  logic             sch_any;
  logic             sw_c;
  logic [PRIORITY_LEVELS-1:0] ready_next;

  logic             head_we;
  logic [TID_W-1:0] head_wd;
  logic             tail_we;
  logic [TID_W-1:0] tail_wd;
  logic             next_we;
  logic [TID_W-1:0] next_wa;
  logic [TID_W-1:0] next_wd;
  logic             prev_we;
  logic [TID_W-1:0] prev_wa;
  logic [TID_W-1:0] prev_wd;

  result_t          res_c;

  assign lvl_sat = (32'(item.priority_req) >= PRIORITY_LEVELS) ?
                   LW'(PRIORITY_LEVELS - 1) : LW'(item.priority_req);

  always_comb begin
    best_c = '0;
    for (int i = PRIORITY_LEVELS - 1; i >= 0; i--) begin
      if (ready[i]) best_c = LW'(i);
    end
  end

  always_comb begin
    case (act_q)
      ACT_INSERT: lvl_addr = lvl_q;
      ACT_REMOVE: lvl_addr = level_rd;
      default:    lvl_addr = best_c;
    endcase
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      act_q <= item.action;
      tid_q <= item.thread_id;
      lvl_q <= lvl_sat;
    end
    if (cmd.rd_link) begin
      level_rd <= level_mem[TIW'(tid_q)];
      next_rd  <= next_mem[TIW'(tid_q)];
      prev_rd  <= prev_mem[TIW'(tid_q)];
    end
    if (cmd.rd_level) begin
      head_rd <= head_mem[lvl_addr];
      tail_rd <= tail_mem[lvl_addr];
      lvl_rq  <= lvl_addr;
    end
  end

  // update decode
  assign tix      = TIW'(tid_q);
  assign in_range = 32'(tid_q) < THREAD_COUNT;
  assign is_ins   = (act_q == ACT_INSERT);
  assign is_rem   = (act_q == ACT_REMOVE);
  assign ins_ok   = is_ins && in_range && !queued[tix];
  assign rem_ok   = is_rem && in_range && queued[tix];
  assign lvl_busy = ready[lvl_rq];
  assign is_head  = (head_rd == tid_q);
  assign is_tail  = (tail_rd == tid_q);
  assign sch_any  = |ready;
  assign sw_c     = !is_ins && !is_rem && sch_any &&
                    (!running_valid || (running_thread != head_rd));

  always_comb begin
    head_we = 1'b0;
    head_wd = tid_q;
    tail_we = 1'b0;
    tail_wd = tid_q;
    next_we = 1'b0;
    next_wa = tail_rd;
    next_wd = tid_q;
    prev_we = 1'b0;
    prev_wa = tid_q;
    prev_wd = tail_rd;
    ready_next = ready;
    if (ins_ok) begin
      tail_we = 1'b1;
      ready_next[lvl_rq] = 1'b1;
      if (lvl_busy) begin
        next_we = 1'b1;
        prev_we = 1'b1;
      end else begin
        head_we = 1'b1;
      end
    end else if (rem_ok) begin
      if (is_head && is_tail) begin
        ready_next[lvl_rq] = 1'b0;
      end else if (is_head) begin
        head_we = 1'b1;
        head_wd = next_rd;
      end else if (is_tail) begin
        tail_we = 1'b1;
        tail_wd = prev_rd;
      end else begin
        next_we = 1'b1;
        next_wa = prev_rd;
        next_wd = next_rd;
        prev_we = 1'b1;
        prev_wa = next_rd;
        prev_wd = prev_rd;
      end
    end
  end

  always_comb begin
    res_c             = '0;
    res_c.error       = (is_ins && !ins_ok) || (is_rem && !rem_ok);
    res_c.has_ready   = |ready_next;
    res_c.ready_mask  = MASK_W'(ready_next);
    if (!is_ins && !is_rem && sch_any) begin
      res_c.picked_thread = head_rd;
      res_c.to_priority   = PRIO_W'(lvl_rq);
      res_c.switched      = sw_c;
      if (sw_c) begin
        res_c.from_valid  = running_valid;
        res_c.left_thread = running_valid ? running_thread : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      if (head_we) head_mem[lvl_rq] <= head_wd;
      if (tail_we) tail_mem[lvl_rq] <= tail_wd;
      if (next_we) next_mem[TIW'(next_wa)] <= next_wd;
      if (prev_we) prev_mem[TIW'(prev_wa)] <= prev_wd;
      if (ins_ok) level_mem[tix] <= lvl_rq;
      result <= res_c;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      ready          <= '0;
      queued         <= '0;
      running_valid  <= 1'b0;
      running_thread <= '0;
      result_valid   <= 1'b0;
    end else begin
      if (cmd.commit) begin
        ready <= ready_next;
        if (ins_ok) queued[tix] <= 1'b1;
        if (rem_ok) queued[tix] <= 1'b0;
        if (sw_c) begin
          running_valid  <= 1'b1;
          running_thread <= head_rd;
        end
        result_valid <= 1'b1;
      end else if (!result_stall) begin
        result_valid <= 1'b0;
      end
    end
  end

  assign status.out_free = !result_valid || !result_stall;

  a_commit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |-> (!result_valid || !result_stall))
    else $error("commit while result register is held");

  a_commit_beat: assert property (@(posedge clk) disable iff (rst)
    cmd.commit |=> result_valid)
    else $error("commit did not present a result beat");

  a_ready_queued: assert property (@(posedge clk) disable iff (rst)
    (|ready) |-> (|queued))
    else $error("ready level with no queued thread");

  a_switch_ready: assert property (@(posedge clk) disable iff (rst)
    result_valid |-> (!result.switched || result.has_ready))
    else $error("switch reported with nothing ready");

  a_running_sticky: assert property (@(posedge clk) disable iff (rst)
    running_valid |=> running_valid)
    else $error("current thread lost");

endmodule

/* rtl/core/priority_bitmap_ready_queue_scheduler_unit.sv */
// top level of the bitmap priority ready-queue scheduler
//
// item channel: item_valid / item_stall / item carries one operation per
// beat (insert a thread at the tail of its level, remove a thread from its
// level, or schedule the head of the lowest-numbered ready level).
// result channel: result_valid / result_stall / result returns exactly one
// beat per accepted item, in order.
// an item steps through the thread link read, the level head and tail read,
// the update that writes the queue memories and the result register, then
// back to idle, in which the next item is accepted; no new item is taken
// before the last one has been updated. the single read and write port of
// each queue memory is why the reads and the update are separate steps.
// while the receiver stalls, the held result stays put and the update cycle
// of the following item waits until the result register can take it.
// after reset the bitmap is empty, no thread is queued and no thread is
// current; no item is taken while rst is high.
module priority_bitmap_ready_queue_scheduler_unit #(
  parameter int PRIORITY_LEVELS = 32,
  parameter int THREAD_COUNT    = 16
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               item_valid,
  output logic               item_stall,
  input  pbrqs_pkg::item_t   item,
  output logic               result_valid,
  input  logic               result_stall,
  output pbrqs_pkg::result_t result
);
  import pbrqs_pkg::*;

  ctrl_cmd_t  cmd;
  dp_status_t status;

  pbrqs_ctrl u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .item_valid (item_valid),
    .item_stall (item_stall),
    .status     (status),
    .cmd        (cmd)
  );

  pbrqs_datapath #(
    .PRIORITY_LEVELS (PRIORITY_LEVELS),
    .THREAD_COUNT    (THREAD_COUNT)
  ) u_datapath (
    .clk          (clk),
    .rst          (rst),
    .item         (item),
    .cmd          (cmd),
    .status       (status),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result)
  );

endmodule
